[src/pcmrc_pkg.sv]
`default_nettype none

package pcmrc_pkg;

   localparam int OUTPUT_RATE_DEF = 48000;
   localparam int MAX_RESULTS     = 6;
   localparam int MIN_RATE        = 8000;
   localparam int ACC_W           = 18;
   localparam int RATE_W          = 17;
   localparam int CNT_W           = $clog2(MAX_RESULTS + 1);

   localparam int CSR_DATA_W = 17;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_BYTES  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INPUT_RATE    = 2'd2;

   localparam logic [2:0] SB_U8  = 3'd1;
   localparam logic [2:0] SB_S16 = 3'd2;
   localparam logic [2:0] SB_S24 = 3'd3;
   localparam logic [2:0] SB_S32 = 3'd4;

   localparam logic [2:0]        SB_RESET   = SB_S16;
   localparam logic [1:0]        CH_RESET   = 2'd2;
   localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(48000);

   typedef struct packed {
      logic load;
      logic sub;
   } cmd_type;

   typedef struct packed {
      logic ge;
      logic ge2;
   } sts_type;

endpackage

`default_nettype wire

[src/pcmrc_datapath.sv]
`default_nettype none

module pcmrc_datapath
   import pcmrc_pkg::*;
#(
   parameter int OUTPUT_RATE = OUTPUT_RATE_DEF
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        csr_wr_en,
   input  wire  [CSR_IDX_W-1:0]       csr_index,
   input  wire  [CSR_DATA_W-1:0]      csr_wdata,
   input  wire  [31:0]                left_raw,
   input  wire  [31:0]                right_raw,
   input  wire  cmd_type              cmd,
   output sts_type                    sts,
   output logic signed [15:0]         left_out,
   output logic signed [15:0]         right_out
);

   logic [2:0]        sample_bytes_ff, sample_bytes_in;
   logic [1:0]        channel_count_ff, channel_count_in;
   logic [RATE_W-1:0] rate_ff, rate_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [15:0]       held_left_ff, held_left_in;
   logic [15:0]       held_right_ff, held_right_in;
   logic [15:0]       dec_left, dec_right;

   function automatic logic [15:0] decode(input logic [2:0] sb, input logic [31:0] r);
      logic [15:0] v;
      v = '0;
      case (sb)
         SB_U8:   v = {r[7:0] ^ 8'h80, 8'h00};
         SB_S16:  v = r[15:0];
         SB_S24:  v = r[23:8];
         SB_S32:  v = r[31:16];
         default: v = '0;
      endcase
      return v;
   endfunction

   // config, rate is stored already clamped to the floor
   always_comb begin
      sample_bytes_in  = sample_bytes_ff;
      channel_count_in = channel_count_ff;
      rate_in          = rate_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SAMPLE_BYTES:  sample_bytes_in  = csr_wdata[2:0];
            CSR_CHANNEL_COUNT: channel_count_in = csr_wdata[1:0];
            CSR_INPUT_RATE: begin
               if (csr_wdata[RATE_W-1:0] < RATE_W'(MIN_RATE)) begin
                  rate_in = RATE_W'(MIN_RATE);
               end else begin
                  rate_in = csr_wdata[RATE_W-1:0];
               end
            end
            default: ;
         endcase
      end
   end

   assign dec_left  = decode(sample_bytes_ff, left_raw);
   assign dec_right = (channel_count_ff > 2'd1) ? decode(sample_bytes_ff, right_raw) : dec_left;

   always_comb begin
      acc_in        = acc_ff;
      held_left_in  = held_left_ff;
      held_right_in = held_right_ff;
      if (cmd.load) begin
         acc_in        = acc_ff + ACC_W'(OUTPUT_RATE);
         held_left_in  = dec_left;
         held_right_in = dec_right;
      end else if (cmd.sub) begin
         acc_in = acc_ff - ACC_W'(rate_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_bytes_ff  <= SB_RESET;
         channel_count_ff <= CH_RESET;
         rate_ff          <= RATE_RESET;
         acc_ff           <= '0;
         held_left_ff     <= '0;
         held_right_ff    <= '0;
      end else begin
         sample_bytes_ff  <= sample_bytes_in;
         channel_count_ff <= channel_count_in;
         rate_ff          <= rate_in;
         acc_ff           <= acc_in;
         held_left_ff     <= held_left_in;
         held_right_ff    <= held_right_in;
      end
   end

   assign sts.ge  = acc_ff >= ACC_W'(rate_ff);
   assign sts.ge2 = acc_ff >= {rate_ff, 1'b0};

   assign left_out  = held_left_ff;
   assign right_out = held_right_ff;

endmodule

`default_nettype wire

[src/pcmrc_ctrl.sv]
`default_nettype none

module pcmrc_ctrl
   import pcmrc_pkg::*;
(
   input  wire      clock,
   input  wire      reset,
   input  wire      req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  wire      rsp_ready,
   output logic     rsp_last,
   input  sts_type  sts,
   output cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EMIT = 2'b10
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             emit;

   assign req_ready = (state_ff == ST_IDLE);
   assign emit      = (state_ff == ST_EMIT) && sts.ge && (cnt_ff < CNT_W'(MAX_RESULTS));
   assign rsp_valid = emit;
   // last when the next subtract drops below the rate or the repeat cap is hit
   assign rsp_last  = emit && (!sts.ge2 || cnt_ff == CNT_W'(MAX_RESULTS - 1));

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit) begin
               if (rsp_ready) begin
                  cmd.sub = 1'b1;
                  cnt_in  = cnt_ff + CNT_W'(1);
               end
            end else if (sts.ge) begin
               // past the cap: reduce the accumulator modulo the rate
               cmd.sub = 1'b1;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   a_cnt_cap: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_RESULTS))
      else $error("result count past cap");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> !rsp_valid)
      else $error("word after last of run");

   a_load_clears: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> cnt_ff == '0 && !req_ready)
      else $error("load did not start a run");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT && !sts.ge |=> req_ready)
      else $error("run finished but input not reopened");

endmodule

`default_nettype wire

[src/pcm_to_stereo16_rate_converter.sv]
// channel | ports                                   | direction
// req     | req_valid/ready, req_left_raw/right_raw | in, one pcm word
// rsp     | rsp_valid/ready, rsp_left_out/right_out,| out, stereo 16-bit words
//         | rsp_last_of_run                         |
// csr     | csr_wr_en, csr_index, csr_wdata         | in, register writes
//
// one input word takes a load, then one subtract per output word (0 to 6),
// further rate subtractions past the repeat cap, and a final check
// the accumulator unit does one compare and subtract per cycle unless rsp stalls
// synchronous active-high reset; back to 48000 Hz, 16-bit stereo
// a stalled rsp word holds until taken; req_ready is low while a run is out
`default_nettype none

module pcm_to_stereo16_rate_converter
   import pcmrc_pkg::*;
#(
   parameter int OUTPUT_RATE = OUTPUT_RATE_DEF
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  wire  [31:0]             req_left_raw,
   input  wire  [31:0]             req_right_raw,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output logic signed [15:0]      rsp_left_out,
   output logic signed [15:0]      rsp_right_out,
   output logic                    rsp_last_of_run,
   input  wire                     csr_wr_en,
   input  wire  [CSR_IDX_W-1:0]    csr_index,
   input  wire  [CSR_DATA_W-1:0]   csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   pcmrc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_last  (rsp_last_of_run),
      .sts       (sts),
      .cmd       (cmd)
   );

   pcmrc_datapath #(
      .OUTPUT_RATE (OUTPUT_RATE)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .left_raw  (req_left_raw),
      .right_raw (req_right_raw),
      .cmd       (cmd),
      .sts       (sts),
      .left_out  (rsp_left_out),
      .right_out (rsp_right_out)
   );

endmodule

`default_nettype wire

[tb/sv/tb_pcm_to_stereo16_rate_converter.sv]
`timescale 1ns / 1ps

module tb_pcm_to_stereo16_rate_converter;
   import pcmrc_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   localparam logic [2:0] SB_NONE = 3'd0;
   localparam logic [2:0] SB_BAD  = 3'd7;

   localparam logic [1:0] CH_ZERO   = 2'd0;
   localparam logic [1:0] CH_MONO   = 2'd1;
   localparam logic [1:0] CH_STEREO = 2'd2;
   localparam logic [1:0] CH_THREE  = 2'd3;

   localparam int DRAIN_CYCLES = 48;
   localparam int RAND_PHASES  = 12;
   localparam int PHASE_WORDS  = 38;
   localparam int NUM_ROWS     = 24;

   typedef struct packed {
      logic signed [15:0] left;
      logic signed [15:0] right;
      logic               last;
   } stereo_frame_t;

   typedef struct packed {
      logic [2:0]         sb;
      logic [1:0]         ch;
      logic [16:0]        rate;
      logic [31:0]        l;
      logic [31:0]        r;
      logic               typed;
      logic signed [15:0] el;
      logic signed [15:0] er;
   } pcm_row_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [31:0]           req_left_raw = '0;
   logic [31:0]           req_right_raw = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b1;
   logic signed [15:0]    rsp_left_out;
   logic signed [15:0]    rsp_right_out;
   logic                  rsp_last_of_run;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   pcm_to_stereo16_rate_converter u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_left_raw    (req_left_raw),
      .req_right_raw   (req_right_raw),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_left_out    (rsp_left_out),
      .rsp_right_out   (rsp_right_out),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #6 clock = ~clock;

   // converter state mirrored by the scoreboard
   logic [2:0]        sb_reg = SB_RESET;
   logic [1:0]        ch_reg = CH_RESET;
   logic [RATE_W-1:0] rate_reg = RATE_RESET;
   logic [ACC_W-1:0]  phase_acc = '0;
   logic [15:0]       held_l = '0;
   logic [15:0]       held_r = '0;

   stereo_frame_t frames_due[$];
   int            words_in = 0;
   int            words_out = 0;
   int            mismatches = 0;
   int            cfg_phases = 0;

   // driver side
   logic        typed_row = 1'b0;
   logic [15:0] typed_l = '0;
   logic [15:0] typed_r = '0;
   logic        req_idle_on = 1'b1;
   logic        rsp_idle_on = 1'b1;
   logic [2:0]  cfg_sb = SB_RESET;
   logic [1:0]  cfg_ch = CH_RESET;
   logic [16:0] cfg_rate = RATE_RESET;
   int          stall_left = 0;

   pcm_row_t dir_rows [0:NUM_ROWS-1] = '{
      '{SB_S16, CH_STEREO, 17'd48000, 32'h0000_7FFF, 32'hFFFF_8000, 1'b1, 32767, -32768},
      '{SB_S16, CH_STEREO, 17'd48000, 32'hABCD_0000, 32'h1234_FFFF, 1'b1, 0, -1},
      '{SB_S24, CH_STEREO, 17'd48000, 32'h007F_FFFF, 32'hFF80_0000, 1'b1, 32767, -32768},
      '{SB_S32, CH_STEREO, 17'd48000, 32'h7FFF_0000, 32'h8000_FFFF, 1'b1, 32767, -32768},
      '{SB_U8,  CH_STEREO, 17'd48000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, -32768, 32512},
      '{SB_U8,  CH_STEREO, 17'd48000, 32'hFFFF_FF80, 32'h0000_007F, 1'b1, 0, -256},
      '{SB_NONE, CH_STEREO, 17'd48000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 0, 0},
      '{SB_BAD, CH_STEREO, 17'd48000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 0, 0},
      '{SB_S16, CH_MONO,   17'd48000, 32'h0000_1234, 32'h0000_5555, 1'b1, 4660, 4660},
      '{SB_S16, CH_ZERO,   17'd48000, 32'hFFFF_8001, 32'h0000_0000, 1'b1, -32767, -32767},
      '{SB_S16, CH_THREE,  17'd48000, 32'h0000_0001, 32'h0000_0002, 1'b1, 1, 2},
      '{SB_S16, CH_STEREO, 17'd8000,  32'h1357_9BDF, 32'h2468_ACE0, 1'b0, 0, 0},
      '{SB_S16, CH_STEREO, 17'd8000,  32'hFFFF_0001, 32'h0001_FFFF, 1'b0, 0, 0},
      '{SB_S24, CH_STEREO, 17'd96000, 32'h1234_5678, 32'h8765_4321, 1'b0, 0, 0},
      '{SB_S24, CH_STEREO, 17'd96000, 32'hDEAD_BEEF, 32'h0BAD_F00D, 1'b0, 0, 0},
      '{SB_S24, CH_STEREO, 17'd96000, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 1'b0, 0, 0},
      '{SB_S16, CH_STEREO, 17'd44100, 32'h0000_4000, 32'h0000_C000, 1'b0, 0, 0},
      '{SB_S16, CH_STEREO, 17'd44100, 32'h0000_0101, 32'h0000_FEFE, 1'b0, 0, 0},
      '{SB_S16, CH_STEREO, 17'd7999,  32'h0000_2222, 32'h0000_3333, 1'b0, 0, 0},
      '{SB_S16, CH_STEREO, 17'd0,     32'h0000_4444, 32'h0000_5555, 1'b0, 0, 0},
      '{SB_S32, CH_MONO,   17'd131071, 32'h1111_0000, 32'h2222_0000, 1'b0, 0, 0},
      '{SB_S32, CH_MONO,   17'd131071, 32'h3333_0000, 32'h4444_0000, 1'b0, 0, 0},
      // accumulator left high by the fast rate, so the repeat cap kicks in
      '{SB_S32, CH_MONO,   17'd8000,  32'h5555_0000, 32'h6666_0000, 1'b0, 0, 0},
      '{SB_S16, CH_STEREO, 17'd96000, 32'h0000_7777, 32'h0000_8888, 1'b0, 0, 0}
   };

   function automatic logic [15:0] to_s16(input logic [31:0] raw);
      case (sb_reg)
         SB_U8:   return {raw[7:0] ^ 8'h80, 8'h00};
         SB_S16:  return raw[15:0];
         SB_S24:  return raw[23:8];
         SB_S32:  return raw[31:16];
         default: return 16'h0000;
      endcase
   endfunction

   // loads the held frame and returns how many output words it yields
   function automatic int hold_and_resample(input logic [31:0] l, input logic [31:0] r);
      logic [ACC_W-1:0] step_rate;
      int               n;
      step_rate = (rate_reg < MIN_RATE) ? ACC_W'(MIN_RATE) : ACC_W'(rate_reg);
      n = 0;
      held_l = to_s16(l);
      held_r = (ch_reg > 1) ? to_s16(r) : held_l;
      phase_acc = phase_acc + ACC_W'(OUTPUT_RATE_DEF);
      while (phase_acc >= step_rate && n < MAX_RESULTS) begin
         phase_acc = phase_acc - step_rate;
         n++;
      end
      if (phase_acc >= step_rate)
         phase_acc = phase_acc % step_rate;
      return n;
   endfunction

   always @(posedge clock) begin : scoreboard
      stereo_frame_t want;
      int            n;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            words_out++;
            if (frames_due.size() == 0) begin
               $display("%0t: unexpected output word left %0d right %0d last %0b",
                        $time, rsp_left_out, rsp_right_out, rsp_last_of_run);
               mismatches++;
            end else begin
               want = frames_due.pop_front();
               if (rsp_left_out !== want.left) begin
                  $display("%0t: left_out expected %0d got %0d",
                           $time, $signed(want.left), rsp_left_out);
                  mismatches++;
               end
               if (rsp_right_out !== want.right) begin
                  $display("%0t: right_out expected %0d got %0d",
                           $time, $signed(want.right), rsp_right_out);
                  mismatches++;
               end
               if (rsp_last_of_run !== want.last) begin
                  $display("%0t: last_of_run expected %0b got %0b",
                           $time, want.last, rsp_last_of_run);
                  mismatches++;
               end
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SAMPLE_BYTES:  sb_reg = csr_wdata[2:0];
               CSR_CHANNEL_COUNT: ch_reg = csr_wdata[1:0];
               CSR_INPUT_RATE:    rate_reg = csr_wdata[RATE_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            words_in++;
            n = hold_and_resample(req_left_raw, req_right_raw);
            if (typed_row) begin
               frames_due.push_back('{typed_l, typed_r, 1'b1});
            end else begin
               for (int i = 0; i < n; i++)
                  frames_due.push_back('{held_l, held_r, i == n - 1});
            end
         end
      end
   end

   // output back-pressure in short random bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 3) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic push_word(input logic [31:0] l, input logic [31:0] r,
                            input logic typed, input logic [15:0] el,
                            input logic [15:0] er);
      if (req_idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      typed_row = typed;
      typed_l = el;
      typed_r = er;
      req_valid <= 1'b1;
      req_left_raw <= l;
      req_right_raw <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // wait until the block has nothing left in flight
   task automatic settle();
      req_valid <= 1'b0;
      while (frames_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
   endtask

   task automatic apply_cfg(input logic [2:0] sb, input logic [1:0] ch, input logic [16:0] rate);
      settle();
      write_csr(CSR_SAMPLE_BYTES, CSR_DATA_W'(sb));
      write_csr(CSR_CHANNEL_COUNT, CSR_DATA_W'(ch));
      write_csr(CSR_INPUT_RATE, CSR_DATA_W'(rate));
      csr_wr_en <= 1'b0;
      cfg_sb = sb;
      cfg_ch = ch;
      cfg_rate = rate;
      cfg_phases++;
   endtask

   function automatic logic [16:0] pick_rate();
      case ($urandom_range(0, 9))
         0:       return 17'd8000;
         1:       return 17'd96000;
         2:       return 17'd48000;
         3:       return 17'd44100;
         4:       return 17'($urandom_range(0, 7999));
         5:       return 17'($urandom_range(96001, 131071));
         6:       return 17'd131071;
         default: return 17'($urandom_range(8000, 96000));
      endcase
   endfunction

   function automatic logic [2:0] pick_sb();
      if ($urandom_range(0, 9) < 8)
         return 3'($urandom_range(1, 4));
      return 3'($urandom_range(0, 7));
   endfunction

   function automatic logic [31:0] rand_raw();
      case ($urandom_range(0, 9))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      logic quiet;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_ROWS; i++) begin
         if (dir_rows[i].sb != cfg_sb || dir_rows[i].ch != cfg_ch ||
             dir_rows[i].rate != cfg_rate)
            apply_cfg(dir_rows[i].sb, dir_rows[i].ch, dir_rows[i].rate);
         push_word(dir_rows[i].l, dir_rows[i].r, dir_rows[i].typed,
                   dir_rows[i].el, dir_rows[i].er);
      end

      // unused register index must leave the config alone
      settle();
      write_csr(CSR_SPARE, '1);
      csr_wr_en <= 1'b0;

      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         quiet = (ph == RAND_PHASES - 1) || ($urandom_range(0, 4) == 0);
         apply_cfg(pick_sb(), 2'($urandom_range(0, 3)), pick_rate());
         req_idle_on = !quiet;
         rsp_idle_on = !quiet;
         for (int k = 0; k < PHASE_WORDS; k++)
            push_word(rand_raw(), rand_raw(), 1'b0, '0, '0);
      end

      req_valid <= 1'b0;
      while (frames_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d pcm words in, %0d stereo words out, %0d register settings",
               words_in, words_out, cfg_phases);
      $display("mismatches seen: %0d", mismatches);
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout with %0d output words still due", frames_due.size());
      $display("TEST FAILED");
      $finish;
   end

endmodule
